// ===== rtl/core/rc6_pkg.sv =====
// Shared types, constants and helper functions for the RC6 block cipher.
package rc6_pkg;

	localparam int WORD_W     = 32;
	localparam int ROUNDS_DEF = 20;
	localparam int KEY_WORDS  = 4;
	localparam int CFG_IDX_W  = 4;

	localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
	localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

	// fixed rotations: round function and key schedule
	localparam logic [4:0] LG_W   = 5'd5;
	localparam logic [4:0] ROT_KS = 5'd3;

	typedef struct packed {
		logic              operation;
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic [WORD_W-1:0] word_c;
		logic [WORD_W-1:0] word_d;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_a;
		logic [WORD_W-1:0] out_b;
		logic [WORD_W-1:0] out_c;
		logic [WORD_W-1:0] out_d;
	} out_beat_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_FILL,
		CMD_MIX_A,
		CMD_MIX_B,
		CMD_PRE,
		CMD_MUL,
		CMD_ROUND,
		CMD_POST
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [1:0] mix_j;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_MIX_RD,
		ST_MIX_A,
		ST_MIX_B,
		ST_PRE_RD,
		ST_PRE,
		ST_MUL,
		ST_RND,
		ST_POST_RD,
		ST_POST
	} state_t;

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
		input logic [4:0] n);
		logic [2*WORD_W-1:0] w;
		w = {x, x} << n;
		return w[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
		input logic [4:0] n);
		logic [2*WORD_W-1:0] w;
		w = {x, x} >> n;
		return w[WORD_W-1:0];
	endfunction

	// f(x) = rotl(x * (2x + 1), 5), low 32 bits of the product
	function automatic logic [WORD_W-1:0] rc6_f(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] m;
		logic [WORD_W-1:0] p;
		m = {x[WORD_W-2:0], 1'b1};
		p = x * m;
		return rotl32(p, LG_W);
	endfunction

endpackage

// ===== rtl/core/rc6_block_cipher.sv =====
// RC6-32 block cipher top level: controller and datapath.
// Each block runs a whitening step, then per round a multiply state with registered products
// followed by a round update state, then the final whitening step that offers the result beat.
// One block is in flight at a time; a new block is accepted only while the controller is idle.
// After a key write the next block first runs the key schedule: a fill of the round key table,
// then three mixing steps per round key, each split into a mix-A and a mix-B state.
// Reset clears control state and the key words to zero and marks the round keys stale.
module rc6_block_cipher #(
	parameter int ROUNDS = rc6_pkg::ROUNDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rc6_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rc6_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          blk_valid,
	output logic                          blk_stall,
	input  rc6_pkg::in_beat_t             blk,
	output logic                          res_valid,
	input  logic                          res_stall,
	output rc6_pkg::out_beat_t            res
);

	import rc6_pkg::*;

	localparam int KIDX_W  = $clog2(2 * ROUNDS + 4);
	localparam int BADDR_W = $clog2(ROUNDS + 2);

	cmd_t               cmd;
	logic [KIDX_W-1:0]  key_idx;
	logic [BADDR_W-1:0] rd_addr;

	rc6_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.blk_valid(blk_valid),
		.blk_op   (blk.operation),
		.blk_stall(blk_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd      (cmd),
		.key_idx  (key_idx),
		.rd_addr  (rd_addr)
	);

	rc6_datapath #(
		.ROUNDS(ROUNDS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.blk      (blk),
		.cmd      (cmd),
		.key_idx  (key_idx),
		.rd_addr  (rd_addr),
		.res      (res)
	);

endmodule

// ===== rtl/core/rc6_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc6_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rc6_datapath.sv =====
// RC6 datapath: key registers, key schedule words, round key banks and cipher state.
module rc6_datapath #(
	parameter int ROUNDS = rc6_pkg::ROUNDS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rc6_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rc6_pkg::WORD_W-1:0]           cfg_data,
	input  rc6_pkg::in_beat_t                    blk,
	input  rc6_pkg::cmd_t                        cmd,
	input  logic [$clog2(2*ROUNDS+4)-1:0]        key_idx,
	input  logic [$clog2(ROUNDS+2)-1:0]          rd_addr,
	output rc6_pkg::out_beat_t                   res
);

	import rc6_pkg::*;

	localparam int NKEYS   = 2 * ROUNDS + 4;
	localparam int KIDX_W  = $clog2(NKEYS);
	localparam int BANK_D  = ROUNDS + 2;

	logic [WORD_W-1:0] key_q [KEY_WORDS];
	logic [WORD_W-1:0] mix_q [KEY_WORDS];
	logic [WORD_W-1:0] ks_a_q, ks_b_q, fill_q;
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, t_q, u_q;
	logic              dec_q;
	out_beat_t         res_q;

	logic              ram_we, we_even, we_odd;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] s_even, s_odd, s_sel;
	logic [WORD_W-1:0] sum_ab, mix_a_new, mix_b_new;
	logic [WORD_W-1:0] enc_b, enc_d, dec_a, dec_c;
	logic [WORD_W-1:0] f_x, f_y, f_t, f_u;

	// round key banks: even keys in one, odd keys in the other
	assign ram_we    = (cmd.op == CMD_FILL) || (cmd.op == CMD_MIX_A);
	assign we_even   = ram_we && !key_idx[0];
	assign we_odd    = ram_we && key_idx[0];
	assign ram_wdata = (cmd.op == CMD_FILL) ? fill_q : mix_a_new;

	rc6_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BANK_D)
	) u_bank_even (
		.clk  (clk),
		.we   (we_even),
		.waddr(key_idx[KIDX_W-1:1]),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(s_even)
	);

	rc6_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BANK_D)
	) u_bank_odd (
		.clk  (clk),
		.we   (we_odd),
		.waddr(key_idx[KIDX_W-1:1]),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(s_odd)
	);

	// key schedule mixing step, split into a mix-A and a mix-B update
	assign s_sel     = key_idx[0] ? s_odd : s_even;
	assign sum_ab    = ks_a_q + ks_b_q;
	assign mix_a_new = rotl32(s_sel + sum_ab, ROT_KS);
	assign mix_b_new = rotl32(mix_q[cmd.mix_j] + sum_ab, sum_ab[4:0]);

	// round function inputs differ by direction
	assign f_x = dec_q ? a_q : b_q;
	assign f_y = dec_q ? c_q : d_q;
	assign f_t = rc6_f(f_x);
	assign f_u = rc6_f(f_y);

	// half round update with the registered t and u
	assign enc_b = rotl32(c_q ^ u_q, t_q[4:0]) + s_odd;
	assign enc_d = rotl32(a_q ^ t_q, u_q[4:0]) + s_even;
	assign dec_a = rotr32(d_q - s_even, u_q[4:0]) ^ t_q;
	assign dec_c = rotr32(b_q - s_odd, t_q[4:0]) ^ u_q;

	// key registers, written through the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				key_q[k] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
			key_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	// working registers, advanced by the controller command
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				a_q    <= blk.word_a;
				b_q    <= blk.word_b;
				c_q    <= blk.word_c;
				d_q    <= blk.word_d;
				dec_q  <= blk.operation;
				ks_a_q <= '0;
				ks_b_q <= '0;
				fill_q <= MAGIC_P;
				for (int k = 0; k < KEY_WORDS; k++) begin
					mix_q[k] <= key_q[k];
				end
			end
			CMD_FILL: begin
				fill_q <= fill_q + MAGIC_Q;
			end
			CMD_MIX_A: begin
				ks_a_q <= mix_a_new;
			end
			CMD_MIX_B: begin
				ks_b_q            <= mix_b_new;
				mix_q[cmd.mix_j]  <= mix_b_new;
			end
			CMD_PRE: begin
				if (dec_q) begin
					a_q <= a_q - s_even;
					c_q <= c_q - s_odd;
				end else begin
					b_q <= b_q + s_even;
					d_q <= d_q + s_odd;
				end
			end
			CMD_MUL: begin
				t_q <= f_t;
				u_q <= f_u;
			end
			CMD_ROUND: begin
				if (dec_q) begin
					a_q <= dec_a;
					b_q <= a_q;
					c_q <= dec_c;
					d_q <= c_q;
				end else begin
					a_q <= b_q;
					b_q <= enc_b;
					c_q <= d_q;
					d_q <= enc_d;
				end
			end
			CMD_POST: begin
				if (dec_q) begin
					res_q.out_a <= a_q;
					res_q.out_b <= b_q - s_even;
					res_q.out_c <= c_q;
					res_q.out_d <= d_q - s_odd;
				end else begin
					res_q.out_a <= a_q + s_even;
					res_q.out_b <= b_q;
					res_q.out_c <= c_q + s_odd;
					res_q.out_d <= d_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

// ===== rtl/core/rc6_ctrl.sv =====
// RC6 controller: sequences key schedule, rounds and the result beat.
module rc6_ctrl #(
	parameter int ROUNDS = rc6_pkg::ROUNDS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rc6_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic                                 blk_valid,
	input  logic                                 blk_op,
	output logic                                 blk_stall,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output rc6_pkg::cmd_t                        cmd,
	output logic [$clog2(2*ROUNDS+4)-1:0]        key_idx,
	output logic [$clog2(ROUNDS+2)-1:0]          rd_addr
);

	import rc6_pkg::*;

	localparam int NKEYS   = 2 * ROUNDS + 4;
	localparam int KIDX_W  = $clog2(NKEYS);
	localparam int BADDR_W = $clog2(ROUNDS + 2);
	localparam int STEPS   = 3 * NKEYS;
	localparam int STEP_W  = $clog2(STEPS);

	localparam logic [KIDX_W-1:0]  IDX_LAST  = KIDX_W'(NKEYS - 1);
	localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(STEPS - 1);
	localparam logic [BADDR_W-1:0] RND_LAST  = BADDR_W'(ROUNDS);
	localparam logic [BADDR_W-1:0] RND_FIRST = BADDR_W'(1);
	localparam logic [BADDR_W-1:0] WHT_ADDR  = BADDR_W'(ROUNDS + 1);

	state_t              state_q, state_nx;
	logic [KIDX_W-1:0]   idx_q, idx_nx;
	logic [1:0]          j_q;
	logic [STEP_W-1:0]   step_q;
	logic [BADDR_W-1:0]  rnd_q;
	logic                keys_ready_q, dec_q, res_valid_q;
	logic                blk_acc, res_free, cfg_hit, idx_last, step_last, rnd_last;
	logic [BADDR_W-1:0]  pre_addr, post_addr;

	assign blk_acc   = blk_valid && !blk_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign cfg_hit   = cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS));
	assign idx_last  = (idx_q == IDX_LAST);
	assign idx_nx    = idx_last ? '0 : idx_q + KIDX_W'(1);
	assign step_last = (step_q == STEP_LAST);
	assign rnd_last  = dec_q ? (rnd_q == RND_FIRST) : (rnd_q == RND_LAST);
	assign pre_addr  = dec_q ? WHT_ADDR : '0;
	assign post_addr = dec_q ? '0 : WHT_ADDR;
	assign blk_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (blk_valid) begin
					state_nx = keys_ready_q ? ST_PRE_RD : ST_FILL;
				end
			end
			ST_FILL: begin
				if (idx_last) begin
					state_nx = ST_MIX_RD;
				end
			end
			ST_MIX_RD:  state_nx = ST_MIX_A;
			ST_MIX_A:   state_nx = ST_MIX_B;
			ST_MIX_B:   state_nx = step_last ? ST_PRE_RD : ST_MIX_A;
			ST_PRE_RD:  state_nx = ST_PRE;
			ST_PRE:     state_nx = ST_MUL;
			ST_MUL:     state_nx = ST_RND;
			ST_RND:     state_nx = rnd_last ? ST_POST_RD : ST_MUL;
			ST_POST_RD: state_nx = ST_POST;
			ST_POST: begin
				if (res_free) begin
					state_nx = ST_IDLE;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	// datapath commands and round key read address
	always_comb begin
		cmd.op    = CMD_NONE;
		cmd.mix_j = j_q;
		key_idx   = idx_q;
		rd_addr   = '0;
		case (state_q)
			ST_IDLE: begin
				if (blk_valid) begin
					cmd.op = CMD_LOAD;
				end
			end
			ST_FILL:   cmd.op = CMD_FILL;
			ST_MIX_RD: rd_addr = idx_q[KIDX_W-1:1];
			ST_MIX_A:  cmd.op = CMD_MIX_A;
			ST_MIX_B: begin
				cmd.op  = CMD_MIX_B;
				rd_addr = idx_nx[KIDX_W-1:1];
			end
			ST_PRE_RD: rd_addr = pre_addr;
			ST_PRE:    cmd.op = CMD_PRE;
			ST_MUL: begin
				cmd.op  = CMD_MUL;
				rd_addr = rnd_q;
			end
			ST_RND:     cmd.op = CMD_ROUND;
			ST_POST_RD: rd_addr = post_addr;
			ST_POST: begin
				rd_addr = post_addr;
				if (res_free) begin
					cmd.op = CMD_POST;
				end
			end
			default: begin
			end
		endcase
	end

	// state, counters, key status and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			j_q          <= '0;
			step_q       <= '0;
			rnd_q        <= '0;
			keys_ready_q <= 1'b0;
			dec_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_IDLE: begin
					if (blk_acc) begin
						dec_q  <= blk_op;
						idx_q  <= '0;
						j_q    <= '0;
						step_q <= '0;
					end
				end
				ST_FILL: idx_q <= idx_nx;
				ST_MIX_B: begin
					idx_q  <= idx_nx;
					j_q    <= j_q + 2'd1;
					step_q <= step_q + STEP_W'(1);
				end
				ST_PRE:  rnd_q <= dec_q ? RND_LAST : RND_FIRST;
				ST_RND:  rnd_q <= dec_q ? rnd_q - BADDR_W'(1) : rnd_q + BADDR_W'(1);
				default: begin
				end
			endcase
			// drop key status on any key write, set it once mixing ends
			if (cfg_hit) begin
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_MIX_B && step_last) begin
				keys_ready_q <= 1'b1;
			end
			// hold the result beat until it is taken
			if (state_q == ST_POST && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// a result beat only appears from the final whitening step
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !$past(res_valid_q)) |-> $past(state_q == ST_POST))
		else $error("result beat raised outside final step");

	// whitening never starts on stale round keys
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRE_RD) |-> keys_ready_q)
		else $error("cipher started with stale round keys");

	// round counter stays within the round range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> (rnd_q != '0 && rnd_q <= RND_LAST))
		else $error("round counter out of range");

	// key index stays inside the round key table while filling and mixing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_A || state_q == ST_FILL) |-> (idx_q <= IDX_LAST))
		else $error("key index beyond round key table");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the RC6 block cipher: key writes, block traffic, predicted results.
module tb_top;
	import rc6_pkg::*;

	localparam int ROUNDS     = ROUNDS_DEF;
	localparam int NUM_RKEYS  = 2 * ROUNDS + 4;
	localparam int LATENCY    = 2 * ROUNDS + 4;
	localparam int IDLE_LIMIT = 4000;
	localparam int MAX_SHOWN  = 10;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);
	localparam int                   REG_LAST_IDX   = 2 ** CFG_IDX_W - 1;

	// published ciphertext for an all-zero key and an all-zero plaintext
	localparam logic [WORD_W-1:0] ZERO_KAT_A = 32'h36a5c38f;
	localparam logic [WORD_W-1:0] ZERO_KAT_B = 32'h78f7b156;
	localparam logic [WORD_W-1:0] ZERO_KAT_C = 32'h4edf29c1;
	localparam logic [WORD_W-1:0] ZERO_KAT_D = 32'h1ea44898;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	logic                 blk_valid;
	logic                 blk_stall;
	in_beat_t             blk;
	logic                 res_valid;
	logic                 res_stall;
	out_beat_t            res;

	rc6_block_cipher #(.ROUNDS(ROUNDS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.blk      (blk),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// cipher state mirrored by the predictor
	logic [WORD_W-1:0] key_words_m [KEY_WORDS];
	logic [WORD_W-1:0] sched_keys  [NUM_RKEYS];
	logic [WORD_W-1:0] mix_words   [KEY_WORDS];
	logic              sched_valid;

	out_beat_t expected_blocks[$];
	out_beat_t want;
	out_beat_t last_out;

	int send_idle_pct;
	int recv_stall_pct;
	int err_count;
	int blocks_sent;
	int results_seen;
	int key_writes;
	int idle_cycles;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [WORD_W-1:0] rol_word(input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] amt);
		int n;
		n = int'(amt[4:0]);
		if (n == 0) begin
			return x;
		end
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] ror_word(input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] amt);
		int n;
		n = int'(amt[4:0]);
		if (n == 0) begin
			return x;
		end
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	// x * (2x + 1), then rotate left by lg(w)
	function automatic logic [WORD_W-1:0] quad_mix(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] odd;
		logic [WORD_W-1:0] prod;
		odd  = {x[WORD_W-2:0], 1'b1};
		prod = x * odd;
		return rol_word(prod, 32'd5);
	endfunction

	task automatic expand_round_keys();
		logic [WORD_W-1:0] sa;
		logic [WORD_W-1:0] sb;
		int                ri;
		int                li;
		sa = '0;
		sb = '0;
		ri = 0;
		li = 0;
		for (int k = 0; k < KEY_WORDS; k++) begin
			mix_words[k] = key_words_m[k];
		end
		sched_keys[0] = MAGIC_P;
		for (int k = 1; k < NUM_RKEYS; k++) begin
			sched_keys[k] = sched_keys[k-1] + MAGIC_Q;
		end
		for (int s = 0; s < 3 * NUM_RKEYS; s++) begin
			sched_keys[ri] = rol_word(sched_keys[ri] + sa + sb, 32'd3);
			sa = sched_keys[ri];
			mix_words[li] = rol_word(mix_words[li] + sa + sb, sa + sb);
			sb = mix_words[li];
			ri = (ri + 1) % NUM_RKEYS;
			li = (li + 1) % KEY_WORDS;
		end
		sched_valid = 1'b1;
	endtask

	task automatic cipher_block(input in_beat_t item, output out_beat_t outw);
		logic [WORD_W-1:0] a, b, c, d, t, u, tmp;
		if (!sched_valid) begin
			expand_round_keys();
		end
		if (item.operation == OP_ENCRYPT) begin
			a = item.word_a;
			b = item.word_b + sched_keys[0];
			c = item.word_c;
			d = item.word_d + sched_keys[1];
			for (int i = 1; i <= ROUNDS; i++) begin
				t = quad_mix(b);
				u = quad_mix(d);
				a = rol_word(a ^ t, u) + sched_keys[2*i];
				c = rol_word(c ^ u, t) + sched_keys[2*i+1];
				tmp = a; a = b; b = c; c = d; d = tmp;
			end
			outw.out_a = a + sched_keys[2*ROUNDS+2];
			outw.out_b = b;
			outw.out_c = c + sched_keys[2*ROUNDS+3];
			outw.out_d = d;
		end else begin
			a = item.word_a - sched_keys[2*ROUNDS+2];
			b = item.word_b;
			c = item.word_c - sched_keys[2*ROUNDS+3];
			d = item.word_d;
			for (int i = ROUNDS; i > 0; i--) begin
				tmp = d; d = c; c = b; b = a; a = tmp;
				u = quad_mix(d);
				t = quad_mix(b);
				c = ror_word(c - sched_keys[2*i+1], t) ^ u;
				a = ror_word(a - sched_keys[2*i], u) ^ t;
			end
			outw.out_a = a;
			outw.out_b = b - sched_keys[0];
			outw.out_c = c;
			outw.out_d = d - sched_keys[1];
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic log_error(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	task automatic compare_word(input string name, input logic [WORD_W-1:0] exp_w,
		input logic [WORD_W-1:0] act_w);
		if (act_w !== exp_w) begin
			log_error($sformatf("result %0d %s expected %h got %h",
				results_seen, name, exp_w, act_w));
		end
	endtask

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_blocks.size() == 0) begin
				log_error($sformatf("result %0d with nothing expected: %h", results_seen, res));
			end else begin
				want = expected_blocks.pop_front();
				compare_word("out_a", want.out_a, res.out_a);
				compare_word("out_b", want.out_b, res.out_b);
				compare_word("out_c", want.out_c, res.out_c);
				compare_word("out_d", want.out_d, res.out_d);
			end
		end
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((blk_valid && !blk_stall) || (res_valid && !res_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// random receiver back-pressure
	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_block(input in_beat_t item, output out_beat_t predicted);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			blk_valid <= 1'b0;
			@(negedge clk);
		end
		blk_valid <= 1'b1;
		blk       <= item;
		do begin
			@(posedge clk);
		end while (blk_stall);
		cipher_block(item, predicted);
		expected_blocks.push_back(predicted);
		last_out = predicted;
		blocks_sent++;
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain_blocks();
		@(negedge clk);
		blk_valid <= 1'b0;
		while (expected_blocks.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (int'(idx) < KEY_WORDS) begin
			key_words_m[idx[1:0]] = data;
			sched_valid           = 1'b0;
		end
		key_writes++;
	endtask

	task automatic write_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
		input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		cfg_write(REG_KEY_WORD_0, k0);
		cfg_write(REG_KEY_WORD_1, k1);
		cfg_write(REG_KEY_WORD_2, k2);
		cfg_write(REG_KEY_WORD_3, k3);
	endtask

	function automatic in_beat_t make_block(input logic op, input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c, input logic [WORD_W-1:0] d);
		in_beat_t item;
		item.operation = op;
		item.word_a    = a;
		item.word_b    = b;
		item.word_c    = c;
		item.word_d    = d;
		return item;
	endfunction

	// mostly random words, with a share of zero, all ones and single-bit patterns
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] one_hot;
		one_hot = 32'h1 << $urandom_range(0, WORD_W - 1);
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return one_hot;
			end
			3: begin
				return ~one_hot;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic in_beat_t random_block();
		logic op;
		op = 1'($urandom_range(0, 1));
		// feed the last result back in, so decrypt often undoes an encrypt
		if ($urandom_range(0, 5) == 0) begin
			return make_block(op, last_out.out_a, last_out.out_b, last_out.out_c,
				last_out.out_d);
		end
		return make_block(op, pick_word(), pick_word(), pick_word(), pick_word());
	endfunction

	// ---------------------------------------------------------------- tests

	// blocks under the reset key, with the published all-zero vector
	task automatic test_reset_key();
		out_beat_t got;
		send_block(make_block(OP_ENCRYPT, '0, '0, '0, '0), got);
		if (got.out_a !== ZERO_KAT_A || got.out_b !== ZERO_KAT_B ||
			got.out_c !== ZERO_KAT_C || got.out_d !== ZERO_KAT_D) begin
			log_error($sformatf("zero-key vector predicted %h", got));
		end
		send_block(make_block(OP_DECRYPT, ZERO_KAT_A, ZERO_KAT_B, ZERO_KAT_C, ZERO_KAT_D), got);
		send_block(make_block(OP_ENCRYPT, '1, '1, '1, '1), got);
		send_block(make_block(OP_DECRYPT, '0, '0, '0, '0), got);
		send_block(make_block(OP_DECRYPT, '1, '1, '1, '1), got);
	endtask

	// key extremes, unused register indexes, same-value rewrite, zero rotations
	task automatic test_key_cases();
		out_beat_t got;
		drain_blocks();
		write_key('1, '1, '1, '1);
		send_block(make_block(OP_ENCRYPT, '0, '0, '0, '0), got);
		send_block(make_block(OP_DECRYPT, '1, '1, '1, '1), got);
		// first-round rotations by zero in both directions
		send_block(make_block(OP_ENCRYPT, $urandom, -sched_keys[0], $urandom,
			-sched_keys[1]), got);
		send_block(make_block(OP_DECRYPT, sched_keys[2*ROUNDS+2], $urandom,
			sched_keys[2*ROUNDS+3], $urandom), got);
		drain_blocks();
		write_key(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h8000_0000);
		send_block(make_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0000,
			32'h0000_0001), got);
		send_block(make_block(OP_DECRYPT, got.out_a, got.out_b, got.out_c, got.out_d), got);
		// writes to unused indexes leave the round keys alone
		drain_blocks();
		cfg_write(CFG_IDX_W'(KEY_WORDS), $urandom);
		cfg_write(CFG_IDX_W'(REG_LAST_IDX), '1);
		send_block(make_block(OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98,
			32'h7654_3210), got);
		send_block(make_block(OP_DECRYPT, 32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98,
			32'h7654_3210), got);
		// rewrite one word with its current value
		drain_blocks();
		cfg_write(REG_KEY_WORD_2, key_words_m[REG_KEY_WORD_2[1:0]]);
		send_block(make_block(OP_ENCRYPT, '0, '1, '0, '1), got);
		// back to the all-zero key
		drain_blocks();
		write_key('0, '0, '0, '0);
		send_block(make_block(OP_ENCRYPT, '0, '0, '0, '0), got);
		send_block(make_block(OP_ENCRYPT, '1, '0, '1, '0), got);
		send_block(make_block(OP_DECRYPT, '0, '1, '0, '1), got);
	endtask

	task automatic change_key();
		int sel;
		sel = $urandom_range(0, 3);
		case ($urandom_range(0, 5))
			0: begin
				write_key($urandom, $urandom, $urandom, $urandom);
			end
			1: begin
				cfg_write(REG_KEY_WORD_0 + CFG_IDX_W'(sel), $urandom);
			end
			2: begin
				write_key('0, '0, '0, '0);
			end
			3: begin
				write_key('1, '1, '1, '1);
			end
			4: begin
				cfg_write(CFG_IDX_W'($urandom_range(KEY_WORDS, REG_LAST_IDX)), $urandom);
				cfg_write(REG_KEY_WORD_0 + CFG_IDX_W'(sel), key_words_m[sel]);
			end
			default: begin
				// keep the current key
			end
		endcase
	endtask

	// random traffic in segments, each after a random key update that may also keep the current key
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		out_beat_t got;
		int        left;
		int        seg;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		left = count;
		while (left > 0) begin
			drain_blocks();
			change_key();
			seg = $urandom_range(8, 40);
			if (seg > left) begin
				seg = left;
			end
			for (int n = 0; n < seg; n++) begin
				send_block(random_block(), got);
			end
			left -= seg;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		blk_valid      = 1'b0;
		blk            = '0;
		res_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		err_count      = 0;
		blocks_sent    = 0;
		results_seen   = 0;
		key_writes     = 0;
		idle_cycles    = 0;
		last_out       = '0;
		sched_valid    = 1'b0;
		for (int k = 0; k < KEY_WORDS; k++) begin
			key_words_m[k] = '0;
			mix_words[k]   = '0;
		end
		for (int k = 0; k < NUM_RKEYS; k++) begin
			sched_keys[k] = '0;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_key();
		test_key_cases();
		test_random_phase(0, 0, 383);
		test_random_phase(68, 0, 383);
		test_random_phase(0, 68, 383);
		test_random_phase(38, 38, 383);

		drain_blocks();
		repeat (LATENCY + 20) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			log_error($sformatf("%0d results never arrived", expected_blocks.size()));
		end

		$display("Sent %0d blocks and checked %0d results across %0d register writes,",
			blocks_sent, results_seen, key_writes);
		$display("encrypt and decrypt, key extremes, with sender gaps and receiver stalls.");
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d errors", err_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== rc6_block_cipher.f =====
rtl/core/rc6_pkg.sv
rtl/core/rc6_ram.sv
rtl/core/rc6_datapath.sv
rtl/core/rc6_ctrl.sv
rtl/core/rc6_block_cipher.sv
test/tb_top.sv
